// ===== rtl/fractal_value_noise_fertility_macros.svh =====
// Assertion macros for the fertility noise block.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef FRACTAL_VALUE_NOISE_FERTILITY_MACROS_SVH
`define FRACTAL_VALUE_NOISE_FERTILITY_MACROS_SVH
`ifndef SYNTHESIS
`define FVNF_ASSERT(label, prop, msg) \
label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define FVNF_IMPLY(label, ante, cons, msg) \
`FVNF_ASSERT(label, (ante) |-> (cons), msg)
`else
`define FVNF_ASSERT(label, prop, msg)
`define FVNF_IMPLY(label, ante, cons, msg)
`endif
`endif

// ===== rtl/fvnf_pkg.sv =====
// Shared constants, tables and types of the fertility noise block.
// No dependencies; used by every module of the block.
package fvnf_pkg;

   localparam int CoordBits = 8;
   localparam int TileW     = 8;
   localparam logic [TileW-1:0] CoordMask =
      (CoordBits >= TileW) ? {TileW{1'b1}} : TileW'((1 << CoordBits) - 1);

   localparam int FracW   = 24;
   localparam int UnitW   = FracW + 1;
   localparam logic [UnitW-1:0] UnitOne = UnitW'(1) << FracW;
   localparam int ScaleW  = 17;
   localparam int PosW    = TileW + ScaleW;
   localparam int CellW   = PosW - 16;
   localparam int CornerW = CellW + 1;
   localparam int WeightW = 23;
   localparam int GridW   = 9;

   localparam logic [63:0] GoldenGamma = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MixMul1     = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MixMul2     = 64'h94d049bb133111eb;
   localparam logic [63:0] HashMulX    = 64'h632be59bd9b4e019;
   localparam logic [63:0] HashMulY    = 64'h85157af5d3f9d65d;

   localparam int NumTerms  = 8;
   localparam int RidgeTerm = 7;
   localparam logic [8:0] SeedOffset [NumTerms] =
      '{9'd101, 9'd102, 9'd103, 9'd104, 9'd211, 9'd212, 9'd213, 9'd307};
   localparam logic [ScaleW-1:0] LatticeScale [NumTerms] =
      '{17'd7209, 17'd14418, 17'd28836, 17'd57672,
        17'd15729, 17'd33817, 17'd72706, 17'd11796};
   localparam logic [WeightW-1:0] LatticeWeight [NumTerms] =
      '{23'd5189752, 23'd2594876, 23'd1297438, 23'd648719,
        23'd2354697, 23'd1295083, 23'd712296, 23'd1677722};
   localparam logic [WeightW-1:0] CampWeight = 23'd1006633;

   localparam logic [14:0] LowQ8  = 15'd4608;
   localparam logic [14:0] SpanQ8 = 15'd17920;
   localparam logic [14:0] TopQ8  = 15'd25600;

   // stage counts of the two parallel branches
   localparam int LatticeLat = 10;
   localparam int CampLat    = 29;
   localparam int InDelay    = CampLat - LatticeLat;

   localparam int CsrIndexW = 3;
   typedef enum logic [CsrIndexW-1:0] {
      CsrNoiseSeed  = 3'd0,
      CsrGridWidth  = 3'd1,
      CsrGridHeight = 3'd2,
      CsrCampX      = 3'd3,
      CsrCampY      = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [GridW-1:0] grid_width;
      logic [GridW-1:0] grid_height;
      logic [TileW-1:0] camp_x;
      logic [TileW-1:0] camp_y;
   } camp_cfg_type;

endpackage

// ===== rtl/fractal_value_noise_fertility.sv =====
// Soil fertility of a map tile from seeded fractal value noise.
// Request channel: req_valid/req_stall with tile coordinates req_tile_x, req_tile_y.
// Response channel: rsp_valid/rsp_stall with rsp_fertility_q8 (unsigned Q7.8).
// A word moves when valid is high and stall is low at a rising clock edge.
// Configuration: csr_wr_en writes csr_wr_data into register csr_index
// (seed, grid width, grid height, camp column, camp row); write only when idle.
// Throughput is one tile per cycle while the receiver does not stall.
// The longest branch is the camp distance path: a 12-stage divider, a
// 13-stage square root and their setup stages; eight noise octaves run
// beside it behind a tile delay line.
// Reset (synchronous, active high) restores the default registers and empties
// the pipeline. When the receiver stalls, the response register holds; the
// pipeline keeps moving while its last stage is empty, and freezes (raising
// req_stall) only when a finished word would have nowhere to go.
// Depends on fvnf_pkg, fvnf_lattice, fvnf_camp and the macros header.
`include "fractal_value_noise_fertility_macros.svh"
module fractal_value_noise_fertility (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fvnf_pkg::TileW-1:0]          req_tile_x,
   input  logic [fvnf_pkg::TileW-1:0]          req_tile_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [14:0]                         rsp_fertility_q8,
   input  logic                                csr_wr_en,
   input  logic [fvnf_pkg::CsrIndexW-1:0]      csr_index,
   input  logic [63:0]                         csr_wr_data
);

   localparam int NT      = fvnf_pkg::NumTerms;
   localparam int TW      = fvnf_pkg::TileW;
   localparam int UW      = fvnf_pkg::UnitW;
   localparam int PipeLat = fvnf_pkg::CampLat + 3;
   localparam int ProdW   = fvnf_pkg::WeightW + UW;
   localparam int PartW   = ProdW + 2;
   localparam int AccW    = PartW + 2;

   logic [63:0]               noise_seed_ff;
   fvnf_pkg::camp_cfg_type    cfg_ff;
   logic [63:0]               seed_oct_ff [NT];

   logic [PipeLat-1:0]        vld_ff;
   logic                      rsp_valid_ff;
   logic [14:0]               rsp_data_ff;

   logic [TW-1:0] dly_x_ff [fvnf_pkg::InDelay];
   logic [TW-1:0] dly_y_ff [fvnf_pkg::InDelay];

   logic [fvnf_pkg::FracW-1:0] term_w [NT];
   logic [UW-1:0]              bias_w;
   logic [ProdW-1:0]           prod_ff [NT+1];
   logic [PartW-1:0]           part_ff [3];
   logic [UW-1:0]              unit_ff;

   logic en, out_load;
   logic [TW-1:0] tx_w, ty_w;
   fvnf_pkg::camp_cfg_type camp_cfg_w;
   logic [UW-1:0]      v2_w;
   logic [UW:0]        ridge_w;
   logic [AccW-1:0]    acc_w;
   logic [AccW-25:0]   unit_raw_w;
   logic [UW-1:0]      unit_in;
   logic [UW+14:0]     scaled_w;
   logic [16:0]        res_w;
   logic [14:0]        res_in;

   // advance while the tail is empty or the response register can take a word
   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign en        = out_load || !vld_ff[PipeLat-1];
   assign req_stall = !en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_fertility_q8 = rsp_data_ff;

   always_comb begin
      tx_w = req_tile_x & fvnf_pkg::CoordMask;
      ty_w = req_tile_y & fvnf_pkg::CoordMask;
      camp_cfg_w = cfg_ff;
      camp_cfg_w.camp_x = cfg_ff.camp_x & fvnf_pkg::CoordMask;
      camp_cfg_w.camp_y = cfg_ff.camp_y & fvnf_pkg::CoordMask;

      v2_w    = {term_w[fvnf_pkg::RidgeTerm], 1'b0};
      ridge_w = (v2_w >= fvnf_pkg::UnitOne) ? ((UW+1)'(2 * fvnf_pkg::UnitOne) - (UW+1)'(v2_w))
                                            : (UW+1)'(v2_w);

      acc_w = AccW'(part_ff[0]) + AccW'(part_ff[1]) + AccW'(part_ff[2]);
      unit_raw_w = acc_w[AccW-1:24];
      unit_in = (unit_raw_w > (AccW-24)'(fvnf_pkg::UnitOne)) ? fvnf_pkg::UnitOne
                                                            : unit_raw_w[UW-1:0];

      scaled_w = (UW+15)'(unit_ff) * (UW+15)'(fvnf_pkg::SpanQ8);
      res_w    = 17'(fvnf_pkg::LowQ8) + 17'(scaled_w[UW+14:24]);
      res_in   = (res_w > 17'(fvnf_pkg::TopQ8)) ? fvnf_pkg::TopQ8 : res_w[14:0];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         noise_seed_ff      <= '0;
         cfg_ff.grid_width  <= 9'd32;
         cfg_ff.grid_height <= 9'd32;
         cfg_ff.camp_x      <= '0;
         cfg_ff.camp_y      <= '0;
      end else if (csr_wr_en) begin
         unique case (fvnf_pkg::csr_index_type'(csr_index))
            fvnf_pkg::CsrNoiseSeed:  noise_seed_ff      <= csr_wr_data;
            fvnf_pkg::CsrGridWidth:  cfg_ff.grid_width  <= csr_wr_data[8:0];
            fvnf_pkg::CsrGridHeight: cfg_ff.grid_height <= csr_wr_data[8:0];
            fvnf_pkg::CsrCampX:      cfg_ff.camp_x      <= csr_wr_data[7:0];
            fvnf_pkg::CsrCampY:      cfg_ff.camp_y      <= csr_wr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NT; k++) begin
         seed_oct_ff[k] <= noise_seed_ff + 64'(fvnf_pkg::SeedOffset[k]);
      end
   end

   // valid bits and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            vld_ff <= {vld_ff[PipeLat-2:0], req_valid};
         end
         if (out_load) begin
            rsp_valid_ff <= vld_ff[PipeLat-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dly_x_ff[0] <= tx_w;
         dly_y_ff[0] <= ty_w;
         for (int i = 1; i < fvnf_pkg::InDelay; i++) begin
            dly_x_ff[i] <= dly_x_ff[i-1];
            dly_y_ff[i] <= dly_y_ff[i-1];
         end
         for (int k = 0; k < NT; k++) begin
            if (k == fvnf_pkg::RidgeTerm) begin
               prod_ff[k] <= ProdW'(fvnf_pkg::LatticeWeight[k]) * ProdW'(ridge_w[UW-1:0]);
            end else begin
               prod_ff[k] <= ProdW'(fvnf_pkg::LatticeWeight[k]) * ProdW'(term_w[k]);
            end
         end
         prod_ff[NT] <= ProdW'(fvnf_pkg::CampWeight) * ProdW'(bias_w);
         for (int j = 0; j < 3; j++) begin
            part_ff[j] <= PartW'(prod_ff[3*j]) + PartW'(prod_ff[3*j+1])
                        + PartW'(prod_ff[3*j+2]);
         end
         unit_ff <= unit_in;
      end
      if (out_load) begin
         rsp_data_ff <= res_in;
      end
   end

   for (genvar k = 0; k < NT; k++) begin : g_octave
      fvnf_lattice u_lattice (
         .clock,
         .en,
         .tile_x      (dly_x_ff[fvnf_pkg::InDelay-1]),
         .tile_y      (dly_y_ff[fvnf_pkg::InDelay-1]),
         .scale       (fvnf_pkg::LatticeScale[k]),
         .seed        (seed_oct_ff[k]),
         .noise_value (term_w[k])
      );
   end

   fvnf_camp u_camp (
      .clock,
      .en,
      .tile_x (tx_w),
      .tile_y (ty_w),
      .cfg    (camp_cfg_w),
      .bias   (bias_w)
   );

   `FVNF_ASSERT(a_accept_enters, (req_valid && !req_stall) |=> vld_ff[0], "accepted word not in first stage")
   `FVNF_IMPLY(a_tail_blocks, vld_ff[PipeLat-1] && rsp_valid_ff && rsp_stall, req_stall, "pipeline moved with a blocked tail")
   `FVNF_IMPLY(a_unit_clamped, vld_ff[PipeLat-1], unit_ff <= fvnf_pkg::UnitOne, "unit sum above one")
   `FVNF_IMPLY(a_result_range, rsp_valid_ff, (rsp_data_ff >= fvnf_pkg::LowQ8) && (rsp_data_ff <= fvnf_pkg::TopQ8), "fertility out of range")

endmodule

// ===== rtl/fvnf_hash.sv =====
// Five-stage pipelined corner hash: coordinate mix and 64-bit finalizer.
// Depends on fvnf_pkg for the hash constants.
module fvnf_hash (
   input  logic                              clock,
   input  logic                              en,
   input  logic [63:0]                       seed,
   input  logic [fvnf_pkg::CornerW-1:0]      cx,
   input  logic [fvnf_pkg::CornerW-1:0]      cy,
   output logic [fvnf_pkg::FracW-1:0]        hash_value
);

   typedef struct packed {
      logic [63:0] ll;
      logic [31:0] lh;
      logic [31:0] hl;
   } part_type;

   // 64x64 truncated product as three 32x32 partial products
   function automatic part_type mul_split(logic [63:0] a, logic [63:0] b);
      part_type    r;
      logic [63:0] t_lh;
      logic [63:0] t_hl;
      r.ll = 64'(a[31:0]) * 64'(b[31:0]);
      t_lh = 64'(a[31:0]) * 64'(b[63:32]);
      t_hl = 64'(a[63:32]) * 64'(b[31:0]);
      r.lh = t_lh[31:0];
      r.hl = t_hl[31:0];
      return r;
   endfunction

   function automatic logic [63:0] mul_join(part_type p);
      logic [31:0] mid;
      mid = p.lh + p.hl;
      return p.ll + {mid, 32'b0};
   endfunction

   part_type    xpart_ff, ypart_ff, apart_ff, bpart_ff;
   logic [63:0] v_ff;
   logic [fvnf_pkg::FracW-1:0] value_ff;

   logic [63:0] v_in, u_w, p_w, w_w, q_w, r_w;

   always_comb begin
      v_in = (seed ^ mul_join(xpart_ff) ^ mul_join(ypart_ff)) + fvnf_pkg::GoldenGamma;
      u_w  = v_ff ^ (v_ff >> 30);
      p_w  = mul_join(apart_ff);
      w_w  = p_w ^ (p_w >> 27);
      q_w  = mul_join(bpart_ff);
      r_w  = q_w ^ (q_w >> 31);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xpart_ff <= mul_split(64'(cx), fvnf_pkg::HashMulX);
         ypart_ff <= mul_split(64'(cy), fvnf_pkg::HashMulY);
         v_ff     <= v_in;
         apart_ff <= mul_split(u_w, fvnf_pkg::MixMul1);
         bpart_ff <= mul_split(w_w, fvnf_pkg::MixMul2);
         value_ff <= r_w[fvnf_pkg::FracW-1:0];
      end
   end

   assign hash_value = value_ff;

endmodule

// ===== rtl/fvnf_lattice.sv =====
// One octave of 2D value noise: lattice position, quintic fade, four corner
// hashes and bilinear blend over ten stages. Depends on fvnf_pkg, fvnf_hash.
module fvnf_lattice (
   input  logic                              clock,
   input  logic                              en,
   input  logic [fvnf_pkg::TileW-1:0]        tile_x,
   input  logic [fvnf_pkg::TileW-1:0]        tile_y,
   input  logic [fvnf_pkg::ScaleW-1:0]       scale,
   input  logic [63:0]                       seed,
   output logic [fvnf_pkg::FracW-1:0]        noise_value
);

   localparam int FW = fvnf_pkg::FracW;
   localparam int UW = fvnf_pkg::UnitW;
   localparam int BW = FW + UW;

   function automatic logic [FW-1:0] q24_mul(logic [FW-1:0] a, logic [FW-1:0] b);
      logic [2*FW-1:0] p;
      p = (2*FW)'(a) * (2*FW)'(b);
      return p[2*FW-1:FW];
   endfunction

   logic [fvnf_pkg::PosW-1:0] px_ff [2];
   logic [FW-1:0] t_f1_ff [2], t2_f1_ff [2];
   logic [FW-1:0] t_f2_ff [2], t3_f2_ff [2];
   logic [FW-1:0] t_f3_ff [2], t3_f3_ff [2], t4_f3_ff [2];
   logic [FW-1:0] t3_f4_ff [2], t4_f4_ff [2], t5_f4_ff [2];
   logic [UW-1:0] fade_ff [2];

   logic [BW-1:0] r0a_ff, r0b_ff, r1a_ff, r1b_ff, ca_ff, cb_ff;
   logic [UW-1:0] fy_b1_ff, fy_b2_ff;
   logic [FW-1:0] row0_ff, row1_ff, value_ff;

   logic [fvnf_pkg::CellW-1:0]   x0_w, y0_w;
   logic [fvnf_pkg::CornerW-1:0] cx0, cx1, cy0, cy1;
   logic [FW-1:0] v00, v10, v01, v11;
   logic [FW-1:0] phase_w [2];
   logic [UW-1:0] fade_in [2];
   logic [29:0]   pos_w [2], neg_w [2], diff_w [2];
   logic [BW-1:0] row0_sum, row1_sum, col_sum;

   always_comb begin
      x0_w = px_ff[0][fvnf_pkg::PosW-1:16];
      y0_w = px_ff[1][fvnf_pkg::PosW-1:16];
      cx0  = {1'b0, x0_w};
      cx1  = {1'b0, x0_w} + fvnf_pkg::CornerW'(1);
      cy0  = {1'b0, y0_w};
      cy1  = {1'b0, y0_w} + fvnf_pkg::CornerW'(1);
      for (int a = 0; a < 2; a++) begin
         phase_w[a] = {px_ff[a][15:0], 8'b0};
         pos_w[a]   = 30'(t5_f4_ff[a]) * 30'd6 + 30'(t3_f4_ff[a]) * 30'd10;
         neg_w[a]   = 30'(t4_f4_ff[a]) * 30'd15;
         diff_w[a]  = pos_w[a] - neg_w[a];
         if (pos_w[a] < neg_w[a]) begin
            fade_in[a] = '0;
         end else if (diff_w[a] > 30'(fvnf_pkg::UnitOne)) begin
            fade_in[a] = fvnf_pkg::UnitOne;
         end else begin
            fade_in[a] = diff_w[a][UW-1:0];
         end
      end
      row0_sum = r0a_ff + r0b_ff;
      row1_sum = r1a_ff + r1b_ff;
      col_sum  = ca_ff + cb_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff[0] <= fvnf_pkg::PosW'(tile_x) * fvnf_pkg::PosW'(scale);
         px_ff[1] <= fvnf_pkg::PosW'(tile_y) * fvnf_pkg::PosW'(scale);
         for (int a = 0; a < 2; a++) begin
            t_f1_ff[a]  <= phase_w[a];
            t2_f1_ff[a] <= q24_mul(phase_w[a], phase_w[a]);
            t_f2_ff[a]  <= t_f1_ff[a];
            t3_f2_ff[a] <= q24_mul(t2_f1_ff[a], t_f1_ff[a]);
            t_f3_ff[a]  <= t_f2_ff[a];
            t3_f3_ff[a] <= t3_f2_ff[a];
            t4_f3_ff[a] <= q24_mul(t3_f2_ff[a], t_f2_ff[a]);
            t3_f4_ff[a] <= t3_f3_ff[a];
            t4_f4_ff[a] <= t4_f3_ff[a];
            t5_f4_ff[a] <= q24_mul(t4_f3_ff[a], t_f3_ff[a]);
            fade_ff[a]  <= fade_in[a];
         end
         // blend along x, then along y
         r0a_ff   <= BW'(v00) * BW'(fvnf_pkg::UnitOne - fade_ff[0]);
         r0b_ff   <= BW'(v10) * BW'(fade_ff[0]);
         r1a_ff   <= BW'(v01) * BW'(fvnf_pkg::UnitOne - fade_ff[0]);
         r1b_ff   <= BW'(v11) * BW'(fade_ff[0]);
         fy_b1_ff <= fade_ff[1];
         row0_ff  <= row0_sum[2*FW-1:FW];
         row1_ff  <= row1_sum[2*FW-1:FW];
         fy_b2_ff <= fy_b1_ff;
         ca_ff    <= BW'(row0_ff) * BW'(fvnf_pkg::UnitOne - fy_b2_ff);
         cb_ff    <= BW'(row1_ff) * BW'(fy_b2_ff);
         value_ff <= col_sum[2*FW-1:FW];
      end
   end

   fvnf_hash u_hash_00 (.clock, .en, .seed, .cx(cx0), .cy(cy0), .hash_value(v00));
   fvnf_hash u_hash_10 (.clock, .en, .seed, .cx(cx1), .cy(cy0), .hash_value(v10));
   fvnf_hash u_hash_01 (.clock, .en, .seed, .cx(cx0), .cy(cy1), .hash_value(v01));
   fvnf_hash u_hash_11 (.clock, .en, .seed, .cx(cx1), .cy(cy1), .hash_value(v11));

   assign noise_value = value_ff;

endmodule

// ===== rtl/fvnf_camp.sv =====
// Camp proximity bias: per-axis distance divide, squares, square root and
// linear falloff over 29 stages. Depends on fvnf_pkg.
module fvnf_camp (
   input  logic                              clock,
   input  logic                              en,
   input  logic [fvnf_pkg::TileW-1:0]        tile_x,
   input  logic [fvnf_pkg::TileW-1:0]        tile_y,
   input  fvnf_pkg::camp_cfg_type            cfg,
   output logic [fvnf_pkg::UnitW-1:0]        bias
);

   localparam int GW         = fvnf_pkg::GridW;
   localparam int NumW       = fvnf_pkg::TileW + 16;
   localparam int DivPerSt   = 2;
   localparam int DivStages  = NumW / DivPerSt;
   localparam int SqW        = 2 * NumW;
   localparam int RadW       = 2 * (SqW / 2 + 2);
   localparam int RootW      = RadW / 2;
   localparam int RemW       = RootW + 2;
   localparam int SqrtPerSt  = 2;
   localparam int SqrtStages = RootW / SqrtPerSt;

   typedef struct packed {
      logic [NumW-1:0] num;
      logic [GW-1:0]   rem;
      logic [NumW-1:0] quo;
   } div_state_type;

   typedef struct packed {
      logic [RadW-1:0]  rad;
      logic [RemW-1:0]  rem;
      logic [RootW-1:0] root;
   } sqrt_state_type;

   // restoring divide, a few quotient bits per stage
   function automatic div_state_type div_step(div_state_type s, logic [GW-1:0] size);
      div_state_type r;
      logic [GW:0]   trial;
      r = s;
      for (int i = 0; i < DivPerSt; i++) begin
         trial = {r.rem, r.num[NumW-1]};
         r.num = {r.num[NumW-2:0], 1'b0};
         if (trial >= {1'b0, size}) begin
            r.rem = GW'(trial - {1'b0, size});
            r.quo = {r.quo[NumW-2:0], 1'b1};
         end else begin
            r.rem = trial[GW-1:0];
            r.quo = {r.quo[NumW-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   // digit-by-digit square root, two radicand bits per iteration
   function automatic sqrt_state_type sqrt_step(sqrt_state_type s);
      sqrt_state_type r;
      logic [RemW+1:0] cur;
      logic [RemW+1:0] trial;
      r = s;
      for (int i = 0; i < SqrtPerSt; i++) begin
         cur   = {r.rem, r.rad[RadW-1:RadW-2]};
         r.rad = {r.rad[RadW-3:0], 2'b00};
         trial = (RemW+2)'({r.root, 2'b01});
         if (cur >= trial) begin
            r.rem  = RemW'(cur - trial);
            r.root = {r.root[RootW-2:0], 1'b1};
         end else begin
            r.rem  = cur[RemW-1:0];
            r.root = {r.root[RootW-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   logic [GW-1:0] size_w [2];
   logic [fvnf_pkg::TileW-1:0] tile_w [2], anchor_w [2], diff_w [2];

   div_state_type  div_ff  [DivStages+1][2];
   logic [SqW-1:0] sq_ff   [2];
   logic [SqW:0]   rad_ff;
   sqrt_state_type root_ff [SqrtStages];
   logic [fvnf_pkg::UnitW-1:0] bias_ff;

   sqrt_state_type root_init;
   logic [RootW+2:0] pull7_w;
   logic [RootW:0]   pull_w;
   logic [fvnf_pkg::UnitW-1:0] bias_in;

   always_comb begin
      tile_w[0]   = tile_x;
      tile_w[1]   = tile_y;
      anchor_w[0] = cfg.camp_x;
      anchor_w[1] = cfg.camp_y;
      size_w[0]   = (cfg.grid_width == '0) ? GW'(1) : cfg.grid_width;
      size_w[1]   = (cfg.grid_height == '0) ? GW'(1) : cfg.grid_height;
      for (int a = 0; a < 2; a++) begin
         diff_w[a] = (tile_w[a] > anchor_w[a]) ? tile_w[a] - anchor_w[a]
                                               : anchor_w[a] - tile_w[a];
      end
      root_init.rad  = RadW'(rad_ff);
      root_init.rem  = '0;
      root_init.root = '0;
      pull7_w = (RootW+3)'(root_ff[SqrtStages-1].root) * (RootW+3)'(7);
      pull_w  = pull7_w[RootW+2:2];
      if (pull_w >= (RootW+1)'(65536)) begin
         bias_in = '0;
      end else begin
         bias_in = {(17'd65536 - 17'(pull_w)), 8'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 2; a++) begin
            div_ff[0][a].num <= {diff_w[a], 16'b0};
            div_ff[0][a].rem <= '0;
            div_ff[0][a].quo <= '0;
            sq_ff[a] <= SqW'(div_ff[DivStages][a].quo) * SqW'(div_ff[DivStages][a].quo);
         end
         rad_ff     <= (SqW+1)'(sq_ff[0]) + (SqW+1)'(sq_ff[1]);
         root_ff[0] <= sqrt_step(root_init);
         bias_ff    <= bias_in;
      end
   end

   for (genvar g = 1; g <= DivStages; g++) begin : g_div
      always_ff @(posedge clock) begin
         if (en) begin
            for (int a = 0; a < 2; a++) begin
               div_ff[g][a] <= div_step(div_ff[g-1][a], size_w[a]);
            end
         end
      end
   end

   for (genvar g = 1; g < SqrtStages; g++) begin : g_root
      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[g] <= sqrt_step(root_ff[g-1]);
         end
      end
   end

   assign bias = bias_ff;

endmodule
